/* rtl/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int TAG_W  = 16;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 9;
    localparam int STAT_W = 2;

    typedef enum logic [0:0] {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One request as it passes from the front end to the heap engine.
    typedef struct packed {
        logic             is_extract;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } req_t;

    // One heap entry: tag in the upper bits, key in the lower bits.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } entry_t;

    localparam int ENTRY_W = TAG_W + KEY_W;

endpackage

/* rtl/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue with insert and extract-minimum requests.
// ----------------------------------------------------------------------------
// An insert sifts up level by level and an extract sifts down; a refused
// request (heap full or empty) goes straight to the result. Every request
// first passes the front queue, and the single RAM port sets each walk.
// One request at a time: no new one is taken until the result is transferred.
// Reset: aresetn is synchronous and active low; it empties the heap and the
// request queue. Heap RAM contents are not cleared.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
    parameter int CAPACITY = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [15:0]                  s_item_tag,
    input  logic [31:0]                  s_priority_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [15:0]                  m_out_tag,
    output logic [31:0]                  m_out_priority,
    output logic [1:0]                   m_status,
    output logic [8:0]                   m_entry_count
);

    // The front end queues up to two request transfers so the input side
    // keeps flowing while the engine walks the heap.
    logic           req_valid;
    logic           req_ready;
    bmhq_pkg::req_t req;

    bmhq_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_item_tag     (s_item_tag),
        .s_priority_req (s_priority_req),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req)
    );

    // The engine owns the heap RAM and the fill count, and it holds the
    // result in an output register until the result transfer completes.
    bmhq_engine #(.CAPACITY(CAPACITY)) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_tag      (m_out_tag),
        .m_out_priority (m_out_priority),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count)
    );

endmodule

/* rtl/bmhq_ram.sv */
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/bmhq_front.sv */
// ----------------------------------------------------------------------------
// bmhq_front
// Accepts requests and holds them in a two-entry queue for the heap engine.
// ----------------------------------------------------------------------------
module bmhq_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [bmhq_pkg::TAG_W-1:0]   s_item_tag,
    input  logic [bmhq_pkg::KEY_W-1:0]   s_priority_req,
    output logic                         req_valid,
    input  logic                         req_ready,
    output bmhq_pkg::req_t               req
);

    bmhq_pkg::req_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;

    assign s_ready   = (cnt_reg != 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = req_valid && req_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= '{is_extract: (s_opcode == bmhq_pkg::OP_EXTRACT),
                                   tag: s_item_tag, key: s_priority_req};
        end
    end

endmodule

/* rtl/bmhq_engine.sv */
// ----------------------------------------------------------------------------
// bmhq_engine
// Heap engine: performs sift-up and sift-down walks over the heap RAM.
// ----------------------------------------------------------------------------
module bmhq_engine #(
    parameter int CAPACITY = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  bmhq_pkg::req_t                req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bmhq_pkg::TAG_W-1:0]    m_out_tag,
    output logic [bmhq_pkg::KEY_W-1:0]    m_out_priority,
    output logic [bmhq_pkg::STAT_W-1:0]   m_status,
    output logic [bmhq_pkg::CNT_W-1:0]    m_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_WAIT, S_UP_CMP,
        S_EX_ROOT, S_EX_LAST, S_EX_WAIT, S_DN_RL, S_DN_RR, S_DN_WL, S_DN_CMP,
        S_DN_WB, S_RESULT
    } state_t;

    state_t                       state_reg;
    logic [FW-1:0]                fill_reg;
    logic [FW-1:0]                pos_reg;       // current node index
    logic [FW:0]                  child_reg;     // left child index (wider)
    bmhq_pkg::entry_t             cur_reg;       // entry being sifted
    bmhq_pkg::entry_t             left_reg;
    logic                         have_r_reg;
    logic                         have_l_reg;

    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [bmhq_pkg::ENTRY_W-1:0] ram_wdata;
    logic [bmhq_pkg::ENTRY_W-1:0] ram_rdata;
    bmhq_pkg::entry_t             rd_entry;

    logic [FW-1:0]                parent_idx;
    logic                         r_smaller;
    logic                         l_smaller;

    assign rd_entry   = bmhq_pkg::entry_t'(ram_rdata);
    assign parent_idx = (pos_reg - FW'(1)) >> 1;
    assign req_ready  = (state_reg == S_IDLE) && !m_valid;

    bmhq_ram #(.WIDTH(bmhq_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Children comparison for sift-down; right only counts if present.
    always_comb begin
        l_smaller = have_l_reg && (left_reg.key < cur_reg.key);
        if (l_smaller) begin
            r_smaller = have_r_reg && (rd_entry.key < left_reg.key);
        end else begin
            r_smaller = have_r_reg && (rd_entry.key < cur_reg.key);
        end
    end

    // The read address is held through S_UP_WAIT and S_DN_WL so that the
    // registered read data still shows the entry the next state compares.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = pos_reg[AW-1:0];
        ram_wdata = cur_reg;
        unique case (state_reg)
            S_UP_RD:   ram_addr = parent_idx[AW-1:0];
            S_UP_WAIT: ram_addr = parent_idx[AW-1:0];
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (pos_reg != '0 && rd_entry.key > cur_reg.key) begin
                    ram_wdata = rd_entry;
                end
            end
            S_EX_ROOT: ram_addr = '0;
            S_EX_LAST: ram_addr = AW'(fill_reg - FW'(1));
            S_DN_RL:   ram_addr = child_reg[AW-1:0];
            S_DN_RR:   ram_addr = AW'(child_reg + (FW+1)'(1));
            S_DN_WL:   ram_addr = AW'(child_reg + (FW+1)'(1));
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (r_smaller) begin
                    ram_wdata = rd_entry;
                end else if (l_smaller) begin
                    ram_wdata = left_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (req_valid && !m_valid) begin
                        m_out_tag      <= '0;
                        m_out_priority <= '0;
                        m_status       <= bmhq_pkg::ST_OK;
                        cur_reg        <= '{tag: req.tag, key: req.key};
                        if (!req.is_extract) begin
                            if (32'(fill_reg) >= 32'(CAPACITY)) begin
                                m_status  <= bmhq_pkg::ST_FULL;
                                state_reg <= S_RESULT;
                            end else begin
                                pos_reg   <= fill_reg;
                                fill_reg  <= fill_reg + FW'(1);
                                state_reg <= (fill_reg == '0) ? S_UP_CMP : S_UP_RD;
                            end
                        end else if (fill_reg == '0) begin
                            m_status  <= bmhq_pkg::ST_EMPTY;
                            state_reg <= S_RESULT;
                        end else begin
                            state_reg <= S_EX_ROOT;
                        end
                    end
                end
                S_UP_RD:   state_reg <= S_UP_WAIT;
                S_UP_WAIT: state_reg <= S_UP_CMP;
                S_UP_CMP: begin
                    if (pos_reg != '0 && rd_entry.key > cur_reg.key) begin
                        pos_reg   <= parent_idx;
                        state_reg <= (parent_idx == '0) ? S_UP_CMP : S_UP_RD;
                    end else begin
                        state_reg <= S_RESULT;
                    end
                end
                S_EX_ROOT: state_reg <= S_EX_LAST;
                S_EX_LAST: begin
                    m_out_tag      <= rd_entry.tag;
                    m_out_priority <= rd_entry.key;
                    fill_reg       <= fill_reg - FW'(1);
                    state_reg      <= S_EX_WAIT;
                end
                S_EX_WAIT: begin
                    cur_reg   <= rd_entry;
                    pos_reg   <= '0;
                    child_reg <= (FW+1)'(1);
                    state_reg <= S_DN_RL;
                end
                S_DN_RL: begin
                    have_l_reg <= (child_reg < (FW+1)'(fill_reg));
                    have_r_reg <= ((child_reg + (FW+1)'(1)) < (FW+1)'(fill_reg));
                    state_reg  <= S_DN_RR;
                end
                S_DN_RR: begin
                    left_reg  <= rd_entry;
                    state_reg <= S_DN_WL;
                end
                S_DN_WL:   state_reg <= S_DN_CMP;
                S_DN_CMP: begin
                    if (r_smaller || l_smaller) begin
                        pos_reg   <= r_smaller ? FW'(child_reg + (FW+1)'(1))
                                               : FW'(child_reg);
                        child_reg <= r_smaller ? {FW'(child_reg + (FW+1)'(1)), 1'b1}
                                               : {FW'(child_reg), 1'b1};
                        state_reg <= S_DN_WB;
                    end else begin
                        state_reg <= S_RESULT;
                    end
                end
                S_DN_WB:   state_reg <= S_DN_RL;
                S_RESULT: begin
                    m_entry_count <= bmhq_pkg::CNT_W'(fill_reg);
                    m_valid       <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/bmhq_checker.sv */
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
module bmhq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out_tag,
    input logic [31:0] m_out_priority,
    input logic [1:0]  m_status
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_priority))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("bad status code");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != 2'd0 |-> m_out_tag == 16'd0 && m_out_priority == 32'd0)
        else $error("error result carries data");

endmodule

bind binary_min_heap_queue bmhq_checker u_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_tag      (m_out_tag),
    .m_out_priority (m_out_priority),
    .m_status       (m_status)
);
